// ===== design/qpp_pkg.sv =====
`timescale 1ns / 1ps

package qpp_pkg;

    // defaults for the top level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 32;

    // fixed field widths
    localparam int IDX_W       = 16;
    localparam int QUAD_W      = 2;
    localparam int NUM_QUADS   = 4;
    localparam int COORD_MAX_W = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [QUAD_W-1:0] Q_LAST = QUAD_W'(NUM_QUADS - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_QSTART,
        ST_EVAL,
        ST_SWAP,
        ST_SWAP2,
        ST_QEND,
        ST_EMIT,
        ST_ECAP
    } seq_state_t;

    // sequencer to output stage
    typedef struct packed {
        logic load;
        logic last;
        logic overflow;
    } emit_ctrl_t;

    // quadrant against the box center, operands sign extended by the caller
    function automatic logic [QUAD_W-1:0] quad_of(
        input logic signed [COORD_MAX_W-1:0] x,
        input logic signed [COORD_MAX_W-1:0] y,
        input logic signed [COORD_MAX_W-1:0] cx,
        input logic signed [COORD_MAX_W-1:0] cy
    );
        logic gx;
        logic gy;
        gx = x > cx;
        gy = y > cy;
        return {gy, gx};
    endfunction

endpackage

// ===== design/qpp_if.sv =====
`timescale 1ns / 1ps

// point item channel
interface qpp_point_if #(
    parameter int COORD_BITS = qpp_pkg::COORD_BITS_DEF
);
    import qpp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_y;
    logic        [IDX_W-1:0]       point_index;
    logic                          last_point;

    modport source (
        output valid, point_x, point_y, point_index, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_index, last_point,
        output ready
    );
endinterface

// result item channel
interface qpp_result_if #(
    parameter int COORD_BITS = qpp_pkg::COORD_BITS_DEF
);
    import qpp_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_y;
    logic        [IDX_W-1:0]       out_index;
    logic        [QUAD_W-1:0]      quadrant;
    logic                          overflow;
    logic                          last_out;

    modport source (
        output valid, out_x, out_y, out_index, quadrant, overflow, last_out,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_index, quadrant, overflow, last_out,
        output ready
    );
endinterface

// configuration write channel
interface qpp_cfg_if #(
    parameter int COORD_BITS = qpp_pkg::COORD_BITS_DEF
);
    import qpp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [COORD_BITS-1:0]  wr_data;

    modport source (
        output valid, reg_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wr_data,
        output ready
    );
endinterface

// ===== design/quadrant_point_partition.sv =====
`timescale 1ns / 1ps

// Quadrant partition of a 2-D point set.
// point_in carries points (x, y, index, last_point); point_out carries the
// partitioned points with their quadrant, the overflow flag and last_out;
// cfg writes the box center (index 0 center_x, index 1 center_y) while idle,
// which the user must keep to; the block does not enforce it. Load: one
// point item per cycle into the point store, per-quadrant counts kept on
// the fly; points past MAX_POINTS are dropped and flag overflow. After the
// last point the store is partitioned in place, one pass per quadrant from
// its group offset to the end: QSTART, EVAL per entry, SWAP and SWAP2 for a
// swapped entry (single read and write port of the store), then QEND. Each
// result item is emitted by a store read (EMIT), then the output register
// (ECAP). No point item is accepted from the last point until the state
// has gone from EMIT back to LOAD after the last result item enters the
// output register. A stalled receiver holds the output register and the
// emission waits; nothing is lost. Reset clears counts, flag and center to
// zero; the store is not cleared, only entries of the current set are read.
module quadrant_point_partition #(
    parameter int MAX_POINTS = qpp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = qpp_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    qpp_point_if.sink     point_in,
    qpp_result_if.source  point_out,
    qpp_cfg_if.sink       cfg
);
    import qpp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = 2 * COORD_BITS + IDX_W;

    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;

    emit_ctrl_t      emit;
    logic            out_free;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [DW-1:0]   ram_rdata;

    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic [QUAD_W-1:0]            rd_q;

    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic [IDX_W-1:0]             out_index_reg;
    logic [QUAD_W-1:0]            quadrant_reg;
    logic                         overflow_reg;
    logic                         last_out_reg;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                REG_CENTER_X: center_x_reg <= cfg.wr_data;
                REG_CENTER_Y: center_y_reg <= cfg.wr_data;
                default:      center_x_reg <= center_x_reg;
            endcase
        end
    end

    // point store
    qpp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // load, partition and emission sequencer
    qpp_seq #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .point_in  (point_in),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_free  (out_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // quadrant of the entry being emitted
    assign rd_x = ram_rdata[DW-1 -: COORD_BITS];
    assign rd_y = ram_rdata[DW-COORD_BITS-1 -: COORD_BITS];
    assign rd_q = quad_of(COORD_MAX_W'(rd_x), COORD_MAX_W'(rd_y),
                          COORD_MAX_W'(center_x_reg), COORD_MAX_W'(center_y_reg));

    // output register
    assign out_free = ~out_valid_reg | point_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (point_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_x_reg     <= rd_x;
            out_y_reg     <= rd_y;
            out_index_reg <= ram_rdata[IDX_W-1:0];
            quadrant_reg  <= rd_q;
            overflow_reg  <= emit.overflow;
            last_out_reg  <= emit.last;
        end
    end

    assign point_out.valid     = out_valid_reg;
    assign point_out.out_x     = out_x_reg;
    assign point_out.out_y     = out_y_reg;
    assign point_out.out_index = out_index_reg;
    assign point_out.quadrant  = quadrant_reg;
    assign point_out.overflow  = overflow_reg;
    assign point_out.last_out  = last_out_reg;

    // a new result only lands in an empty output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> !out_valid_reg)
        else $error("result item loaded over a pending one");

endmodule

// ===== design/qpp_ram.sv =====
`timescale 1ns / 1ps

module qpp_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/qpp_seq.sv =====
`timescale 1ns / 1ps

module qpp_seq #(
    parameter int MAX_POINTS = qpp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = qpp_pkg::COORD_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    qpp_point_if.sink                                     point_in,
    input  logic signed [COORD_BITS-1:0]                  center_x,
    input  logic signed [COORD_BITS-1:0]                  center_y,
    input  logic                                          out_free,
    output qpp_pkg::emit_ctrl_t                           emit,
    output logic                                          ram_we,
    output logic [$clog2(MAX_POINTS)-1:0]                 ram_waddr,
    output logic [2*COORD_BITS+qpp_pkg::IDX_W-1:0]        ram_wdata,
    output logic [$clog2(MAX_POINTS)-1:0]                 ram_raddr,
    input  logic [2*COORD_BITS+qpp_pkg::IDX_W-1:0]        ram_rdata
);
    import qpp_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = 2 * COORD_BITS + IDX_W;

    seq_state_t          state_reg, state_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       qcnt_reg [NUM_QUADS];
    logic                ovf_reg;
    logic [QUAD_W-1:0]   q_reg;
    logic [CW-1:0]       base_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       wr_reg;
    logic [CW-1:0]       k_reg;
    logic [DW-1:0]       hold_reg;

    logic                in_fire;
    logic                full;
    logic [QUAD_W-1:0]   load_q;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic [QUAD_W-1:0]   rd_q;
    logic                match;
    logic                do_swap;
    logic [CW-1:0]       i_inc;
    logic                more;
    logic [CW:0]         base_sum;
    logic [CW-1:0]       base_cap;
    logic [CW-1:0]       k_inc;

    // load side
    assign in_fire = point_in.valid & point_in.ready;
    assign full    = cnt_reg == CW'(MAX_POINTS);
    assign load_q  = quad_of(COORD_MAX_W'(point_in.point_x), COORD_MAX_W'(point_in.point_y),
                             COORD_MAX_W'(center_x), COORD_MAX_W'(center_y));

    // scan side: entry read last cycle
    assign rd_x    = ram_rdata[DW-1 -: COORD_BITS];
    assign rd_y    = ram_rdata[DW-COORD_BITS-1 -: COORD_BITS];
    assign rd_q    = quad_of(COORD_MAX_W'(rd_x), COORD_MAX_W'(rd_y),
                             COORD_MAX_W'(center_x), COORD_MAX_W'(center_y));
    assign match   = rd_q == q_reg;
    assign do_swap = match && (wr_reg != i_reg);
    assign i_inc   = i_reg + 1'b1;
    assign more    = i_inc < cnt_reg;
    assign k_inc   = k_reg + 1'b1;

    // next group offset, clipped to the loaded count
    assign base_sum = {1'b0, base_reg} + {1'b0, qcnt_reg[q_reg]};
    assign base_cap = (base_sum > {1'b0, cnt_reg}) ? cnt_reg : base_sum[CW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && point_in.last_point)
                begin
                    state_next = ST_QSTART;
                end
            end
            ST_QSTART:
            begin
                state_next = (base_reg < cnt_reg) ? ST_EVAL : ST_QEND;
            end
            ST_EVAL:
            begin
                if (do_swap)
                begin
                    state_next = ST_SWAP;
                end
                else
                begin
                    state_next = more ? ST_EVAL : ST_QEND;
                end
            end
            ST_SWAP:
            begin
                state_next = ST_SWAP2;
            end
            ST_SWAP2:
            begin
                state_next = more ? ST_EVAL : ST_QEND;
            end
            ST_QEND:
            begin
                state_next = (q_reg == Q_LAST) ? ST_EMIT : ST_QSTART;
            end
            ST_EMIT:
            begin
                if (k_reg == cnt_reg)
                begin
                    state_next = ST_LOAD;
                end
                else if (out_free)
                begin
                    state_next = ST_ECAP;
                end
            end
            ST_ECAP:
            begin
                state_next = ST_EMIT;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // memory port and handshake outputs
    always_comb
    begin
        point_in.ready = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[AW-1:0];
        ram_wdata      = {point_in.point_x, point_in.point_y, point_in.point_index};
        ram_raddr      = i_reg[AW-1:0];
        emit.load      = 1'b0;
        emit.last      = k_inc == cnt_reg;
        emit.overflow  = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                point_in.ready = 1'b1;
                ram_we         = in_fire & ~full;
            end
            ST_QSTART:
            begin
                ram_raddr = base_reg[AW-1:0];
            end
            ST_EVAL:
            begin
                ram_raddr = do_swap ? wr_reg[AW-1:0] : i_inc[AW-1:0];
            end
            ST_SWAP:
            begin
                // entry at the write pointer moves to the scan position
                ram_we    = 1'b1;
                ram_waddr = i_reg[AW-1:0];
                ram_wdata = ram_rdata;
            end
            ST_SWAP2:
            begin
                // matching entry lands at the write pointer, prefetch next
                ram_we    = 1'b1;
                ram_waddr = wr_reg[AW-1:0];
                ram_wdata = hold_reg;
                ram_raddr = i_inc[AW-1:0];
            end
            ST_QEND:
            begin
                ram_raddr = i_reg[AW-1:0];
            end
            ST_EMIT:
            begin
                ram_raddr = k_reg[AW-1:0];
            end
            ST_ECAP:
            begin
                emit.load = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            for (int n = 0; n < NUM_QUADS; n++)
            begin
                qcnt_reg[n] <= '0;
            end
            ovf_reg   <= 1'b0;
            q_reg     <= '0;
            base_reg  <= '0;
            i_reg     <= '0;
            wr_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (!full)
                        begin
                            cnt_reg          <= cnt_reg + 1'b1;
                            qcnt_reg[load_q] <= qcnt_reg[load_q] + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (point_in.last_point)
                        begin
                            q_reg    <= '0;
                            base_reg <= '0;
                        end
                    end
                end
                ST_QSTART:
                begin
                    i_reg  <= base_reg;
                    wr_reg <= base_reg;
                end
                ST_EVAL:
                begin
                    if (!do_swap)
                    begin
                        if (match)
                        begin
                            wr_reg <= wr_reg + 1'b1;
                        end
                        i_reg <= i_inc;
                    end
                end
                ST_SWAP:
                begin
                    i_reg <= i_reg;
                end
                ST_SWAP2:
                begin
                    wr_reg <= wr_reg + 1'b1;
                    i_reg  <= i_inc;
                end
                ST_QEND:
                begin
                    base_reg <= base_cap;
                    q_reg    <= q_reg + 1'b1;
                    k_reg    <= '0;
                end
                ST_EMIT:
                begin
                    // set delivered: back to an empty store
                    if (k_reg == cnt_reg)
                    begin
                        cnt_reg <= '0;
                        for (int n = 0; n < NUM_QUADS; n++)
                        begin
                            qcnt_reg[n] <= '0;
                        end
                        ovf_reg <= 1'b0;
                    end
                end
                ST_ECAP:
                begin
                    k_reg <= k_inc;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // matching entry held during a swap
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL && do_swap)
        begin
            hold_reg <= ram_rdata;
        end
    end

    // quadrant counts add up to the loaded count while loading
    logic [CW+1:0] qsum;
    assign qsum = (CW+2)'(qcnt_reg[0]) + (CW+2)'(qcnt_reg[1])
                + (CW+2)'(qcnt_reg[2]) + (CW+2)'(qcnt_reg[3]);

    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> qsum == (CW+2)'(cnt_reg))
        else $error("quadrant counts disagree with loaded count");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWAP |-> wr_reg < i_reg)
        else $error("swap with write pointer not behind scan position");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> i_reg < cnt_reg)
        else $error("scan beyond loaded entries");

    a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_QSTART |-> base_reg <= cnt_reg)
        else $error("group offset beyond loaded count");

endmodule
